[hw/rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// operation and register codes, and the request and response payloads.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Storage and counter widths that follow from the geometry
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   // Fixed field widths
   localparam int IDX_W   = 11;
   localparam int BYTE_W  = 8;
   localparam int OP_W    = 2;
   localparam int CSR_IDX_W = 1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BACKSPACE_CODE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE_ATTRIBUTE = 1'd1;

   // Register reset values and fixed characters
   localparam logic [BYTE_W-1:0] BACKSPACE_RESET = 8'd8;
   localparam logic [BYTE_W-1:0] ERASE_RESET     = 8'd15;
   localparam logic [BYTE_W-1:0] NEWLINE_CODE    = 8'd10;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [BYTE_W-1:0] char_code;
      logic [BYTE_W-1:0] color;
      idx_type           read_index;
   } req_payload_type;

   typedef struct packed {
      idx_type           cursor_pos;
      logic              cell_valid;
      idx_type           cell_index;
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] cell_attr;
      logic              scrolled;
   } rsp_payload_type;

endpackage

[hw/rtl/tcw_req_if.sv]
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel of the text console writer: valid, ready and payload.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   import tcw_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/tcw_rsp_if.sv]
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel of the text console writer: valid, ready and payload.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text terminal with a screen store of character and attribute cells, a
// cursor, newline, backspace, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries put, clear and read requests; rsp_chan returns exactly one
//   response per request with the cursor after the request and the cell that
//   was written or read. The user must write the backspace code and erase
//   attribute via csr_* only while it is idle; the block does not enforce it.
//   The screen sits in a single-port-write, single-port-read memory with
//   registered read data. One request is worked on at a time; req_chan.ready
//   is high only in the idle state.
//   A put without scroll and the other opcodes pass from idle to the done
//   state, which loads the response register once it is free; a read of a
//   cell passes through the read state first, and a put that scrolls or a
//   clear through the sweep state.
//   Scroll and clear run one memory sweep, one cell per cycle, through the
//   shared address counter and read-modify-write path.
//   After reset a clearing pass zeroes the memory, one cell per cycle, over
//   all CELLS cells (2000 at 80x25); ready stays low meanwhile, CSR writes are
//   still taken.
//   A stalled response is held in the output register; the next request is
//   still taken and its result waits until that register is free.
// ----------------------------------------------------------------------------
module text_console_writer (
   input  logic                                clock,
   input  logic                                reset,
   tcw_req_if.sink                             req_chan,
   tcw_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcw_pkg::BYTE_W-1:0]          csr_write_data
);
   import tcw_pkg::*;

   // Sequencer state codes
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam int LAST_ROW_START = CELLS - COLUMNS;

   // Screen memory
   logic [2*BYTE_W-1:0] screen_mem [CELLS];
   logic [2*BYTE_W-1:0] mem_rd_data_ff;
   logic                mem_we;
   addr_type            mem_wa;
   logic [2*BYTE_W-1:0] mem_wd;
   addr_type            mem_ra;

   // Control and payload registers
   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   addr_type            pend_dst_ff, pend_dst_in;
   logic                pend_mask_ff, pend_mask_in;
   logic                clear_mode_ff, clear_mode_in;
   addr_type            cursor_ff, cursor_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [BYTE_W-1:0]   backspace_ff, backspace_in;
   logic [BYTE_W-1:0]   erase_ff, erase_in;
   rsp_payload_type     res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic                accept;
   addr_type            line_start;
   addr_type            sweep_src;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   assign line_start = cursor_ff - addr_type'(col_ff);

   // Source cell of the sweep: row below for scroll copies, same cell otherwise
   always_comb begin
      if (!clear_mode_ff && (cnt_ff < CNT_W'(LAST_ROW_START))) begin
         sweep_src = ADDR_W'(cnt_ff + CNT_W'(COLUMNS));
      end else begin
         sweep_src = ADDR_W'(cnt_ff);
      end
   end

   // Configuration writes
   always_comb begin
      backspace_in = backspace_ff;
      erase_in     = erase_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BACKSPACE_CODE:  backspace_in = csr_write_data;
            CSR_ERASE_ATTRIBUTE: erase_in     = csr_write_data;
            default:             ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      pend_in        = 1'b0;
      pend_dst_in    = pend_dst_ff;
      pend_mask_in   = pend_mask_ff;
      clear_mode_in  = clear_mode_ff;
      cursor_in      = cursor_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_wa         = '0;
      mem_wd         = '0;
      mem_ra         = '0;

      case (state_ff)
         // Zero every cell after reset
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'(cnt_ff);
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Decode a transfer and update the cursor
         ST_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = ST_DONE;
               cnt_in   = '0;
               case (req_chan.payload.opcode)
                  OP_PUT: begin
                     if (req_chan.payload.char_code == NEWLINE_CODE) begin
                        col_in = '0;
                        if (row_ff == ROW_W'(ROWS - 1)) begin
                           cursor_in       = line_start;
                           res_in.scrolled = 1'b1;
                           clear_mode_in   = 1'b0;
                           state_in        = ST_SWEEP;
                        end else begin
                           cursor_in = line_start + addr_type'(COLUMNS);
                           row_in    = row_ff + 1'b1;
                        end
                     end else if (req_chan.payload.char_code == backspace_ff) begin
                        if (cursor_ff != '0) begin
                           cursor_in         = cursor_ff - 1'b1;
                           mem_we            = 1'b1;
                           mem_wa            = cursor_ff - 1'b1;
                           mem_wd            = {erase_ff, BYTE_W'(0)};
                           res_in.cell_valid = 1'b1;
                           res_in.cell_index = idx_type'(cursor_ff - 1'b1);
                           res_in.cell_attr  = erase_ff;
                           if (col_ff == '0) begin
                              col_in = COL_W'(COLUMNS - 1);
                              row_in = row_ff - 1'b1;
                           end else begin
                              col_in = col_ff - 1'b1;
                           end
                        end
                     end else begin
                        mem_we            = 1'b1;
                        mem_wa            = cursor_ff;
                        mem_wd            = {req_chan.payload.color,
                                             req_chan.payload.char_code};
                        res_in.cell_valid = 1'b1;
                        res_in.cell_index = idx_type'(cursor_ff);
                        res_in.cell_char  = req_chan.payload.char_code;
                        res_in.cell_attr  = req_chan.payload.color;
                        if (cursor_ff == addr_type'(CELLS - 1)) begin
                           cursor_in       = addr_type'(LAST_ROW_START);
                           col_in          = '0;
                           row_in          = ROW_W'(ROWS - 1);
                           res_in.scrolled = 1'b1;
                           clear_mode_in   = 1'b0;
                           state_in        = ST_SWEEP;
                        end else if (col_ff == COL_W'(COLUMNS - 1)) begin
                           cursor_in = cursor_ff + 1'b1;
                           col_in    = '0;
                           row_in    = row_ff + 1'b1;
                        end else begin
                           cursor_in = cursor_ff + 1'b1;
                           col_in    = col_ff + 1'b1;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     cursor_in     = '0;
                     col_in        = '0;
                     row_in        = '0;
                     clear_mode_in = 1'b1;
                     state_in      = ST_SWEEP;
                  end
                  OP_READ: begin
                     if (32'(req_chan.payload.read_index) < 32'(CELLS)) begin
                        mem_ra            = addr_type'(req_chan.payload.read_index);
                        res_in.cell_valid = 1'b1;
                        res_in.cell_index = req_chan.payload.read_index;
                        state_in          = ST_READ;
                     end
                  end
                  default: ;
               endcase
               res_in.cursor_pos = idx_type'(cursor_in);
            end
         end

         // Capture the registered cell
         ST_READ: begin
            res_in.cell_char = mem_rd_data_ff[BYTE_W-1:0];
            res_in.cell_attr = mem_rd_data_ff[2*BYTE_W-1:BYTE_W];
            state_in         = ST_DONE;
         end

         // Read one cell ahead, write back the previous one
         ST_SWEEP: begin
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = pend_dst_ff;
               mem_wd = pend_mask_ff ?
                        {mem_rd_data_ff[2*BYTE_W-1:BYTE_W], BYTE_W'(0)} :
                        mem_rd_data_ff;
            end
            if (cnt_ff != CNT_W'(CELLS)) begin
               mem_ra       = sweep_src;
               pend_in      = 1'b1;
               pend_dst_in  = ADDR_W'(cnt_ff);
               pend_mask_in = clear_mode_ff || (cnt_ff >= CNT_W'(LAST_ROW_START));
               cnt_in       = cnt_ff + 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end

         // Load the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_INIT;
      endcase
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_wa] <= mem_wd;
      end
      mem_rd_data_ff <= screen_mem[mem_ra];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         backspace_ff <= BACKSPACE_RESET;
         erase_ff     <= ERASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         backspace_ff <= backspace_in;
         erase_ff     <= erase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_dst_ff    <= pend_dst_in;
      pend_mask_ff   <= pend_mask_in;
      clear_mode_ff  <= clear_mode_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

[hw/rtl/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_port_checks
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_port_checks (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input tcw_pkg::rsp_payload_type rsp_payload
);
   import tcw_pkg::*;

   // Clearing pass follows reset: no transfer taken right after it
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready directly after reset");

   // One request at a time: ready drops after each request transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready straight after a request transfer");

   // A scroll always leaves the cursor at the start of the last row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.scrolled) |->
      (rsp_payload.cursor_pos == idx_type'(CELLS - COLUMNS)))
      else $error("scroll reported with cursor off the last row start");

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule

bind text_console_writer tcw_port_checks u_tcw_port_checks (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
